/* src/pwb_pkg.sv */
// Package for the particle wall bounce step block.
// Holds the item structs, register codes, sequencer states and shared helpers.
// No dependencies.
package pwb_pkg;

    localparam int POS_W      = 20;
    localparam int VEL_W      = 16;
    localparam int TIME_W     = 16;
    localparam int CNT_OUT_W  = 4;
    localparam int FIELD_W    = 12;
    localparam int FRAC_POS   = 8;
    localparam int PROD_SHIFT = 14;
    localparam int DIVIDEND_W = POS_W + PROD_SHIFT;
    localparam int CFG_IDX_W  = 4;

    localparam int MAX_BOUNCES_DEFAULT = 8;
    localparam int BOUNCE_SAT          = 15;

    localparam logic [FIELD_W-1:0] FIELD_WIDTH_RESET  = 12'd1280;
    localparam logic [FIELD_W-1:0] FIELD_HEIGHT_RESET = 12'd720;

    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_HEIGHT = 4'd1;

    typedef struct packed {
        logic        [POS_W-1:0]  pos_x;
        logic        [POS_W-1:0]  pos_y;
        logic signed [VEL_W-1:0]  vel_x;
        logic signed [VEL_W-1:0]  vel_y;
        logic        [TIME_W-1:0] step_time;
    } in_item_t;

    typedef struct packed {
        logic        [POS_W-1:0]     new_pos_x;
        logic        [POS_W-1:0]     new_pos_y;
        logic signed [VEL_W-1:0]     new_vel_x;
        logic signed [VEL_W-1:0]     new_vel_y;
        logic        [CNT_OUT_W-1:0] bounce_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOP,
        ST_MUL,
        ST_TEST,
        ST_DIV,
        ST_DECIDE,
        ST_MMUL,
        ST_MAPPLY,
        ST_UPDATE,
        ST_DONE
    } state_t;

    function automatic logic signed [VEL_W-1:0] neg_sat(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v == {1'b1, {(VEL_W-1){1'b0}}})
            r = {1'b0, {(VEL_W-1){1'b1}}};
        else
            r = -v;
        return r;
    endfunction

endpackage

/* src/pwb_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Produces a TIME_W-bit quotient of a DIVIDEND_W-bit dividend by a VEL_W-bit divisor.
// Depends on pwb_pkg.
module pwb_div
    import pwb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [VEL_W-1:0]      divisor,
    output logic [TIME_W-1:0]     quotient,
    output logic                  done
);

    localparam int DSH_W = VEL_W + TIME_W - 1;
    localparam int STEP_W = $clog2(TIME_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DSH_W-1:0]      dsh_reg, dsh_next;
    logic [TIME_W-1:0]     q_reg, q_next;
    logic [DIVIDEND_W-1:0] dsh_ext;

    assign dsh_ext = DIVIDEND_W'(dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend;
            dsh_next  = {divisor, {(TIME_W-1){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_ext)
            begin
                rem_next = rem_reg - dsh_ext;
                q_next   = {q_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[TIME_W-2:0], 1'b0};
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(TIME_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

/* src/particle_wall_bounce_step_top.sv */
// Top level of the particle wall bounce step block: sequencer, shared multiplier,
// field registers and result register. Depends on pwb_pkg and pwb_div.
//
//   channel | signals                              | direction
//   in      | in_valid, in_stall, in_data          | item in, transfer when valid & !stall
//   out     | out_valid, out_stall, out_data       | result out, transfer when valid & !stall
//   cfg     | cfg_valid, cfg_ready, cfg_index/data | register write, valid & ready
//
// An item runs loop iterations until its time is used up or MAX_BOUNCES bounces are counted;
// each iteration runs the bit-serial divider for every axis that hits, and the single multiplier
// serves both axes in turn; a step with no wall impact runs one iteration.
// Reset loads the field registers with 1280 x 720 and empties the result register.
// in_stall is high while an item is in work; a stalled result waits in its register.
module particle_wall_bounce_step_top
    import pwb_pkg::*;
#(
    parameter int MAX_BOUNCES = MAX_BOUNCES_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(MAX_BOUNCES + 1);

    state_t                  state_reg, state_next;
    logic [FIELD_W-1:0]      fw_reg, fw_next;
    logic [FIELD_W-1:0]      fh_reg, fh_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    axis_reg, axis_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_data_reg, out_data_next;

    logic        [POS_W-1:0]  p_reg [2];
    logic        [POS_W-1:0]  p_next [2];
    logic signed [VEL_W-1:0]  v_reg [2];
    logic signed [VEL_W-1:0]  v_next [2];
    logic        [TIME_W-1:0] ht_reg [2];
    logic        [TIME_W-1:0] ht_next [2];
    logic                     hit_reg [2];
    logic                     hit_next [2];
    logic        [TIME_W-1:0] t_reg, t_next;
    logic        [TIME_W-1:0] nt_reg, nt_next;
    logic signed [31:0]       prod_reg, prod_next;

    logic        [POS_W-1:0]      lim [2];
    logic                         land [2];
    logic signed [VEL_W-1:0]      v_sel;
    logic        [POS_W-1:0]      p_sel;
    logic        [POS_W-1:0]      lim_sel;
    logic        [TIME_W-1:0]     mul_time;
    logic signed [32:0]           prod_full;
    logic signed [35:0]           end_pos;
    logic signed [35:0]           wall_end;
    logic                         hit_sel;
    logic        [POS_W-1:0]      gap_dist;
    logic        [VEL_W-1:0]      speed;
    logic                         div_start;
    logic        [TIME_W-1:0]     div_q;
    logic                         div_done;
    logic        [TIME_W-1:0]     ht_div;
    logic signed [32:0]           rnd_sum;
    logic signed [18:0]           disp;
    logic signed [21:0]           pos_sum;
    logic        [POS_W-1:0]      pos_clamped;
    logic        [POS_W-1:0]      in_px, in_py;

    assign lim[0] = {fw_reg, {FRAC_POS{1'b0}}};
    assign lim[1] = {fh_reg, {FRAC_POS{1'b0}}};

    assign v_sel    = v_reg[axis_reg];
    assign p_sel    = p_reg[axis_reg];
    assign lim_sel  = lim[axis_reg];
    assign mul_time = (state_reg == ST_MMUL) ? nt_reg : t_reg;

    assign prod_full = v_sel * $signed({1'b0, mul_time});
    assign prod_next = prod_full[31:0];

    assign end_pos  = $signed({2'b00, p_sel, {PROD_SHIFT{1'b0}}}) + 36'(prod_reg);
    assign wall_end = $signed({2'b00, lim_sel, {PROD_SHIFT{1'b0}}});
    assign hit_sel  = (v_sel[VEL_W-1] && (end_pos <= 36'sd0))
                   || (!v_sel[VEL_W-1] && (v_sel != '0) && (end_pos >= wall_end));
    assign gap_dist = v_sel[VEL_W-1] ? p_sel : (lim_sel - p_sel);
    assign speed    = v_sel[VEL_W-1] ? (~v_sel + 16'd1) : v_sel;
    assign ht_div   = (div_q > t_reg) ? t_reg : div_q;

    assign rnd_sum = 33'(prod_reg) + 33'sd8192;
    assign disp    = rnd_sum[32:14];
    assign pos_sum = $signed({2'b00, p_sel}) + 22'(disp);

    always_comb
    begin
        if (pos_sum[21])
            pos_clamped = '0;
        else if (pos_sum[20:0] > {1'b0, lim_sel})
            pos_clamped = lim_sel;
        else
            pos_clamped = pos_sum[19:0];
    end

    assign land[0] = hit_reg[0] && (ht_reg[0] == nt_reg);
    assign land[1] = hit_reg[1] && (ht_reg[1] == nt_reg);

    assign in_px = (in_data.pos_x > lim[0]) ? lim[0] : in_data.pos_x;
    assign in_py = (in_data.pos_y > lim[1]) ? lim[1] : in_data.pos_y;

    pwb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({gap_dist, {PROD_SHIFT{1'b0}}}),
        .divisor  (speed),
        .quotient (div_q),
        .done     (div_done)
    );

    always_comb
    begin
        fw_next = fw_reg;
        fh_next = fh_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIELD_WIDTH:  fw_next = cfg_data;
                REG_FIELD_HEIGHT: fh_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        axis_next      = axis_reg;
        t_next         = t_reg;
        nt_next        = nt_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        ht_next        = ht_reg;
        hit_next       = hit_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_next[0]  = in_px;
                    p_next[1]  = in_py;
                    v_next[0]  = in_data.vel_x;
                    v_next[1]  = in_data.vel_y;
                    t_next     = in_data.step_time;
                    cnt_next   = '0;
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP:
            begin
                axis_next = 1'b0;
                if ((t_reg == '0) || (cnt_reg == CNT_W'(MAX_BOUNCES)))
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                hit_next[axis_reg] = hit_sel;
                if (hit_sel)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    ht_next[axis_reg] = t_reg;
                    axis_next         = 1'b1;
                    state_next        = axis_reg ? ST_DECIDE : ST_MUL;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ht_next[axis_reg] = ht_div;
                    axis_next         = 1'b1;
                    state_next        = axis_reg ? ST_DECIDE : ST_MUL;
                end
            end
            ST_DECIDE:
            begin
                nt_next    = (ht_reg[0] < ht_reg[1]) ? ht_reg[0] : ht_reg[1];
                axis_next  = 1'b0;
                state_next = ST_MMUL;
            end
            ST_MMUL:
            begin
                state_next = ST_MAPPLY;
            end
            ST_MAPPLY:
            begin
                if (land[axis_reg])
                    p_next[axis_reg] = v_sel[VEL_W-1] ? '0 : lim_sel;
                else
                    p_next[axis_reg] = pos_clamped;
                axis_next  = 1'b1;
                state_next = axis_reg ? ST_UPDATE : ST_MMUL;
            end
            ST_UPDATE:
            begin
                if (!hit_reg[0] && !hit_reg[1])
                begin
                    t_next = '0;
                end
                else
                begin
                    if (land[0])
                        v_next[0] = neg_sat(v_reg[0]);
                    if (land[1])
                        v_next[1] = neg_sat(v_reg[1]);
                    t_next   = t_reg - nt_reg;
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = ST_LOOP;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.new_pos_x    = p_reg[0];
                    out_data_next.new_pos_y    = p_reg[1];
                    out_data_next.new_vel_x    = v_reg[0];
                    out_data_next.new_vel_y    = v_reg[1];
                    out_data_next.bounce_count = (32'(cnt_reg) > 32'(BOUNCE_SAT))
                                               ? CNT_OUT_W'(BOUNCE_SAT)
                                               : CNT_OUT_W'(cnt_reg);
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fw_reg        <= FIELD_WIDTH_RESET;
            fh_reg        <= FIELD_HEIGHT_RESET;
            cnt_reg       <= '0;
            axis_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fw_reg        <= fw_next;
            fh_reg        <= fh_next;
            cnt_reg       <= cnt_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        v_reg        <= v_next;
        ht_reg       <= ht_next;
        hit_reg      <= hit_next;
        t_reg        <= t_next;
        nt_reg       <= nt_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule
